@@ design/lrs_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and helpers for the line range selector.
// No dependencies; the selector, cell and parser files import this package.
package lrs_pkg;

  localparam int RANGE_SLOTS = 16;
  localparam int VALUE_CAP   = 1000000000;
  localparam int COUNT_W     = $clog2(RANGE_SLOTS + 1);

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_CHAR  = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  localparam logic       KIND_PARSE = 1'b0;
  localparam logic       KIND_QUERY = 1'b1;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  typedef enum logic [11:0] {
    PH_START = 12'b0000_0000_0001,
    PH_LO    = 12'b0000_0000_0010,
    PH_COLON = 12'b0000_0000_0100,
    PH_CTX0  = 12'b0000_0000_1000,
    PH_CTX1  = 12'b0000_0001_0000,
    PH_PLUS0 = 12'b0000_0010_0000,
    PH_PLUS1 = 12'b0000_0100_0000,
    PH_HI    = 12'b0000_1000_0000,
    PH_T0    = 12'b0001_0000_0000,
    PH_T1    = 12'b0010_0000_0000,
    PH_T2    = 12'b0100_0000_0000,
    PH_ERR   = 12'b1000_0000_0000
  } phase_t;

  // One stored range.
  typedef struct packed {
    logic [30:0] lo;
    logic [30:0] hi;
    logic        tail;
    logic        open;
  } range_t;

  // Query transaction walking down the cell chain.
  typedef struct packed {
    logic        valid;
    logic [31:0] line;
    logic [31:0] total;
    logic        sel;
    logic        unb;
    logic [30:0] mx;
  } token_t;

  // End-of-argument report from the parser.
  typedef struct packed {
    logic       done;
    logic [1:0] status;
    logic       append;
    range_t     rng;
  } finish_t;

  // Multiply by ten, add a digit, saturate at the cap.
  function automatic logic [29:0] add_digit(input logic [29:0] v, input logic [3:0] d);
    logic [33:0] t;
    t = {1'b0, v, 3'b000} + {3'b000, v, 1'b0} + {30'd0, d};
    if (t > 34'(VALUE_CAP)) t = 34'(VALUE_CAP);
    return t[29:0];
  endfunction

endpackage

@@ design/lrs_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for requests and responses.
// Depends on nothing but plain logic types.
interface lrs_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [7:0]  char_code;
  logic        last;
  logic [31:0] line_number;
  logic [31:0] total_lines;
  modport source (output valid, operation, char_code, last, line_number, total_lines,
                  input ready);
  modport sink   (input valid, operation, char_code, last, line_number, total_lines,
                  output ready);
endinterface

interface lrs_rsp_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [1:0]  status;
  logic        selected;
  logic [30:0] max_line;
  logic        unbounded;
  logic        wants_total;
  logic [29:0] largest_tail;
  modport source (output valid, kind, status, selected, max_line, unbounded, wants_total,
                  largest_tail, input ready);
  modport sink   (input valid, kind, status, selected, max_line, unbounded, wants_total,
                  largest_tail, output ready);
endinterface

@@ design/line_range_selector.sv @@
`timescale 1ns / 1ps
// Line range selector. Clear and character transactions complete at acceptance; a
// character that ends an argument has its status loaded into the output register
// at the edge that accepts it. A query walks a chain of RANGE_SLOTS range cells,
// one cell per cycle, then waits in a holding register until the output register
// is free; no new transaction is taken until its answer is loaded. Any transaction
// also waits while the output register holds an untaken result.
// Depends on lrs_pkg, lrs_if, lrs_cell and lrs_parser.
module line_range_selector import lrs_pkg::*; (
  input logic         clk,
  input logic         rst,
  lrs_req_if.sink     req,
  lrs_rsp_if.source   rsp
);

  logic               qbusy;
  logic               acc;
  logic               out_free;
  logic [COUNT_W-1:0] count;
  logic               tail_seen;
  logic [29:0]        tail_max;
  finish_t            fin;
  token_t             tok [RANGE_SLOTS+1];
  token_t             pend;
  logic               is_clear, is_char, is_query;

  assign out_free  = !rsp.valid || rsp.ready;
  assign req.ready = !qbusy && out_free;
  assign acc       = req.valid && req.ready;
  assign is_clear  = acc && (req.operation == OP_CLEAR);
  assign is_char   = acc && (req.operation == OP_CHAR);
  assign is_query  = acc && (req.operation == OP_QUERY);

  lrs_parser u_parser (
    .clk   (clk),
    .rst   (rst),
    .clear (is_clear),
    .step  (is_char),
    .c     (req.char_code),
    .last  (req.last),
    .full  (count >= COUNT_W'(RANGE_SLOTS)),
    .fin   (fin)
  );

  // Track table fill and tail summary
  always_ff @(posedge clk) begin
    if (rst || is_clear) begin
      count     <= '0;
      tail_seen <= 1'b0;
      tail_max  <= '0;
    end else if (fin.append) begin
      count <= count + COUNT_W'(1);
      if (fin.rng.tail) begin
        tail_seen <= 1'b1;
        if (fin.rng.lo[29:0] > tail_max) tail_max <= fin.rng.lo[29:0];
      end
    end
  end

  // Launch a query token
  always_ff @(posedge clk) begin
    if (rst) begin
      tok[0].valid <= 1'b0;
    end else begin
      tok[0].valid <= is_query;
    end
    tok[0].line  <= req.line_number;
    tok[0].total <= req.total_lines;
    tok[0].sel   <= (count == '0);
    tok[0].unb   <= (count == '0);
    tok[0].mx    <= '0;
  end

  for (genvar i = 0; i < RANGE_SLOTS; i++) begin : g_cell
    lrs_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .wr      (fin.append && (count == COUNT_W'(i))),
      .wdata   (fin.rng),
      .used    (count > COUNT_W'(i)),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
  end

  // Hold the finished query until the output register frees
  always_ff @(posedge clk) begin
    if (rst) begin
      pend.valid <= 1'b0;
    end else if (tok[RANGE_SLOTS].valid) begin
      pend.valid <= 1'b1;
    end else if (out_free) begin
      pend.valid <= 1'b0;
    end
    if (tok[RANGE_SLOTS].valid) begin
      pend.line  <= tok[RANGE_SLOTS].line;
      pend.total <= tok[RANGE_SLOTS].total;
      pend.sel   <= tok[RANGE_SLOTS].sel;
      pend.unb   <= tok[RANGE_SLOTS].unb;
      pend.mx    <= tok[RANGE_SLOTS].mx;
    end
  end

  // Busy from query acceptance until its answer is loaded
  always_ff @(posedge clk) begin
    if (rst) begin
      qbusy <= 1'b0;
    end else if (is_query) begin
      qbusy <= 1'b1;
    end else if (pend.valid && out_free) begin
      qbusy <= 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (fin.done || (pend.valid && out_free)) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
    if (fin.done) begin
      rsp.kind         <= KIND_PARSE;
      rsp.status       <= fin.status;
      rsp.selected     <= 1'b0;
      rsp.max_line     <= '0;
      rsp.unbounded    <= 1'b0;
      rsp.wants_total  <= 1'b0;
      rsp.largest_tail <= '0;
    end else if (pend.valid && out_free) begin
      rsp.kind         <= KIND_QUERY;
      rsp.status       <= ST_OK;
      rsp.selected     <= pend.sel;
      rsp.max_line     <= pend.unb ? 31'd0 : pend.mx;
      rsp.unbounded    <= pend.unb;
      rsp.wants_total  <= tail_seen;
      rsp.largest_tail <= tail_max;
    end
  end

endmodule

@@ design/lrs_cell.sv @@
`timescale 1ns / 1ps
// One range cell: holds a range and folds it into a passing query token.
// Depends on lrs_pkg.
module lrs_cell import lrs_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   wr,
  input  range_t wdata,
  input  logic   used,
  input  token_t tok_in,
  output token_t tok_out
);

  range_t rng;

  // Hold the stored range
  always_ff @(posedge clk) begin
    if (wr) rng <= wdata;
  end

  logic signed [34:0] lo_eff;
  logic signed [34:0] tail_lo;
  logic               hit;
  token_t             tok_next;

  // Fold this range into the token
  always_comb begin
    tail_lo = $signed({3'b000, tok_in.total}) - $signed({4'b0000, rng.lo}) + 35'sd1;
    if (rng.tail) lo_eff = (tail_lo < 35'sd1) ? 35'sd1 : tail_lo;
    else          lo_eff = $signed({4'b0000, rng.lo});
    hit = ($signed({3'b000, tok_in.line}) >= lo_eff) &&
          (rng.open || ({1'b0, tok_in.line} <= {2'b00, rng.hi}));
    tok_next = tok_in;
    if (used) begin
      if (hit) tok_next.sel = 1'b1;
      if (rng.open || rng.tail) tok_next.unb = 1'b1;
      else if (rng.hi > tok_in.mx) tok_next.mx = rng.hi;
    end
  end

  // Advance the token one cell
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
    end
    tok_out.line  <= tok_next.line;
    tok_out.total <= tok_next.total;
    tok_out.sel   <= tok_next.sel;
    tok_out.unb   <= tok_next.unb;
    tok_out.mx    <= tok_next.mx;
  end

endmodule

@@ design/lrs_parser.sv @@
`timescale 1ns / 1ps
// Argument parser: one character per transaction, reports at argument end.
// Depends on lrs_pkg.
module lrs_parser import lrs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       clear,
  input  logic       step,
  input  logic [7:0] c,
  input  logic       last,
  input  logic       full,
  output finish_t    fin
);

  phase_t      phase, phase_next;
  logic [29:0] first, first_next;
  logic [29:0] second, second_next;
  logic        have_lo, have_lo_next;

  logic        is_dig;
  logic [3:0]  d;
  logic        ok;
  range_t      r;
  logic [30:0] f31, s31;

  // Next parse state for this character
  always_comb begin
    is_dig       = (c >= CH_ZERO) && (c <= CH_NINE);
    d            = 4'(c - CH_ZERO);
    phase_next   = PH_ERR;
    first_next   = first;
    second_next  = second;
    have_lo_next = have_lo;
    case (phase)
      PH_START: begin
        if (c == CH_MINUS) phase_next = PH_T0;
        else if (is_dig) begin
          first_next = add_digit(30'd0, d);
          phase_next = PH_LO;
        end else if (c == CH_COLON) phase_next = PH_COLON;
      end
      PH_LO: begin
        if (is_dig) begin
          first_next = add_digit(first, d);
          phase_next = PH_LO;
        end else if (c == CH_COLON && first != 30'd0) begin
          have_lo_next = 1'b1;
          phase_next   = PH_COLON;
        end
      end
      PH_COLON: begin
        if (c == CH_COLON && have_lo) phase_next = PH_CTX0;
        else if (c == CH_PLUS && have_lo) phase_next = PH_PLUS0;
        else if (is_dig) begin
          second_next = add_digit(30'd0, d);
          phase_next  = PH_HI;
        end
      end
      PH_CTX0, PH_CTX1: begin
        if (is_dig) begin
          second_next = add_digit((phase == PH_CTX0) ? 30'd0 : second, d);
          phase_next  = PH_CTX1;
        end
      end
      PH_PLUS0, PH_PLUS1: begin
        if (is_dig) begin
          second_next = add_digit((phase == PH_PLUS0) ? 30'd0 : second, d);
          phase_next  = PH_PLUS1;
        end
      end
      PH_HI: begin
        if (is_dig) begin
          second_next = add_digit(second, d);
          phase_next  = PH_HI;
        end
      end
      PH_T0, PH_T1: begin
        if (is_dig) begin
          first_next = add_digit((phase == PH_T0) ? 30'd0 : first, d);
          phase_next = PH_T1;
        end else if (c == CH_COLON && phase == PH_T1) phase_next = PH_T2;
      end
      default: phase_next = PH_ERR;
    endcase
    // A zero character is not fed
    if (c == 8'd0) begin
      phase_next   = phase;
      first_next   = first;
      second_next  = second;
      have_lo_next = have_lo;
    end
  end

  // Build the range from the state after this character
  always_comb begin
    f31    = {1'b0, first_next};
    s31    = {1'b0, second_next};
    ok     = 1'b0;
    r.lo   = '0;
    r.hi   = '0;
    r.tail = 1'b0;
    r.open = 1'b0;
    case (phase_next)
      PH_LO: begin
        ok = (first_next != 30'd0); r.lo = f31; r.hi = f31;
      end
      PH_COLON: begin
        ok = have_lo_next; r.lo = f31; r.open = 1'b1;
      end
      PH_CTX1: begin
        ok   = 1'b1;
        r.lo = (second_next >= first_next) ? 31'd1 : f31 - s31;
        r.hi = f31 + s31;
      end
      PH_PLUS1: begin
        ok = 1'b1; r.lo = f31; r.hi = f31 + s31;
      end
      PH_HI: begin
        ok = (second_next != 30'd0); r.lo = have_lo_next ? f31 : 31'd1; r.hi = s31;
      end
      PH_T2: begin
        ok = (first_next != 30'd0); r.lo = f31; r.tail = 1'b1; r.open = 1'b1;
      end
      default: ok = 1'b0;
    endcase
    fin.done   = step && ((c == 8'd0) || last);
    fin.rng    = r;
    fin.append = fin.done && !full && ok;
    if (full)    fin.status = ST_FULL;
    else if (ok) fin.status = ST_OK;
    else         fin.status = ST_INVALID;
  end

  // Advance or restart the parse
  always_ff @(posedge clk) begin
    if (rst || clear || fin.done) begin
      phase   <= PH_START;
      first   <= '0;
      second  <= '0;
      have_lo <= 1'b0;
    end else if (step) begin
      phase   <= phase_next;
      first   <= first_next;
      second  <= second_next;
      have_lo <= have_lo_next;
    end
  end

endmodule
